// File: design/rdq_pkg.sv
// Shared types and constants for the restricted deque.
`timescale 1ns / 1ps

package rdq_pkg;

  localparam int DEPTH = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_DUMP       = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_REFUSED = 2'd3;

  localparam logic MODE_INPUT_RESTRICTED  = 1'b0;
  localparam logic MODE_OUTPUT_RESTRICTED = 1'b1;

  typedef struct packed {
    logic [2:0]               command;
    logic signed [DATA_W-1:0] push_value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic [1:0]               status;
    logic                     last;
  } out_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SHR,
    OP_SHL,
    OP_PUT,
    OP_ROT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     tail_hit;
  } cell_ctl_t;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

endpackage

// File: design/rdq_cell.sv
// One storage cell of the deque chain.
`timescale 1ns / 1ps

module rdq_cell
  import rdq_pkg::*;
(
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic signed [DATA_W-1:0] left_d,
  input  logic signed [DATA_W-1:0] right_d,
  input  logic signed [DATA_W-1:0] front_d,
  input  logic signed [DATA_W-1:0] push_d,
  output logic signed [DATA_W-1:0] q
);

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      OP_HOLD: data_nxt = data_r;
      OP_SHR:  data_nxt = left_d;
      OP_SHL:  data_nxt = right_d;
      OP_PUT:  data_nxt = ctl.tail_hit ? push_d : data_r;
      OP_ROT:  data_nxt = ctl.tail_hit ? front_d : right_d;
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

// File: design/restricted_deque_core.sv
// Top level of the restricted double-ended queue.
`timescale 1ns / 1ps

// Bounded deque of DEPTH signed 32-bit words held in a chain of cells, the front
// entry always in cell 0. Push and pop commands each yield one result transaction;
// a new command is taken in the cycle its predecessor's result is taken. A dump
// hands the stored entries to the output register front first, waiting while the
// output is stalled, rotating the occupied cells once round so the queue is left
// as it was; no command is taken until the final entry has been handed to the
// output register. The user must write restriction_mode through the cfg_ port
// while the block is idle (not enforced); 0 refuses back push, 1 refuses back pop.
module restricted_deque_core
  import rdq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_wdata
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] dump_cnt_r, dump_cnt_nxt;
  logic [CNT_W-1:0] tail_pos;
  logic [CNT_W-1:0] cnt_m1;
  logic             mode_r;
  logic             out_valid_r;
  out_t             out_data_r;
  out_t             res;
  logic             load;
  logic             out_free;
  logic             in_acc;
  logic             is_full;
  logic             is_empty;
  cell_op_t         op;
  logic signed [DATA_W-1:0] cell_q [DEPTH];

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;
  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign is_empty = (count_r == '0);
  assign cnt_m1   = count_r - 1'b1;
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_data.command == CMD_DUMP && !is_empty) begin
          state_nxt = S_DUMP;
        end
      end
      S_DUMP: begin
        if (out_free && dump_cnt_r == CNT_W'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    op           = OP_HOLD;
    tail_pos     = cnt_m1;
    count_nxt    = count_r;
    dump_cnt_nxt = dump_cnt_r;
    load         = 1'b0;
    res.result_value = '0;
    res.status       = ST_OK;
    res.last         = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          load = 1'b1;
          case (in_data.command)
            CMD_PUSH_FRONT: begin
              if (is_full) begin
                res.status = ST_FULL;
              end else begin
                op        = OP_SHR;
                count_nxt = count_r + 1'b1;
              end
            end
            CMD_PUSH_BACK: begin
              if (mode_r == MODE_INPUT_RESTRICTED) begin
                res.status = ST_REFUSED;
              end else if (is_full) begin
                res.status = ST_FULL;
              end else begin
                op        = OP_PUT;
                tail_pos  = count_r;
                count_nxt = count_r + 1'b1;
              end
            end
            CMD_POP_FRONT: begin
              if (is_empty) begin
                res.status = ST_EMPTY;
              end else begin
                op               = OP_SHL;
                res.result_value = cell_q[0];
                count_nxt        = cnt_m1;
              end
            end
            CMD_POP_BACK: begin
              if (mode_r == MODE_OUTPUT_RESTRICTED) begin
                res.status = ST_REFUSED;
              end else if (is_empty) begin
                res.status = ST_EMPTY;
              end else begin
                res.result_value = cell_q[cnt_m1[IDX_W-1:0]];
                count_nxt        = cnt_m1;
              end
            end
            CMD_DUMP: begin
              if (is_empty) begin
                res.status = ST_EMPTY;
              end else begin
                load         = 1'b0;
                dump_cnt_nxt = count_r;
              end
            end
            default: res.status = ST_REFUSED;
          endcase
        end
      end
      S_DUMP: begin
        if (out_free) begin
          load             = 1'b1;
          op               = OP_ROT;
          res.result_value = cell_q[0];
          res.last         = (dump_cnt_r == CNT_W'(1));
          dump_cnt_nxt     = dump_cnt_r - 1'b1;
        end
      end
      default: op = OP_HOLD;
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctl_t                ctl;
    logic signed [DATA_W-1:0] left_d;
    logic signed [DATA_W-1:0] right_d;

    assign ctl.op       = op;
    assign ctl.tail_hit = (tail_pos == CNT_W'(i));

    if (i == 0) begin : g_first
      assign left_d = in_data.push_value;
    end else begin : g_mid
      assign left_d = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign right_d = '0;
    end else begin : g_inner
      assign right_d = cell_q[i+1];
    end

    rdq_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .left_d  (left_d),
      .right_d (right_d),
      .front_d (cell_q[0]),
      .push_d  (in_data.push_value),
      .q       (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      dump_cnt_r  <= '0;
      mode_r      <= MODE_INPUT_RESTRICTED;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      dump_cnt_r <= dump_cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_wdata;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: design/rdq_checker.sv
// Port-level checks for the restricted deque, bound to the top level.
`timescale 1ns / 1ps

module rdq_checker
  import rdq_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input in_t  in_data,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("command changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.last)
    else $error("error result not marked last");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.result_value == '0)
    else $error("error result carries a value");

  a_dump_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> in_stall)
    else $error("command taken in the middle of a dump");

endmodule

bind restricted_deque_core rdq_checker u_rdq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: tb/restricted_deque_core_test.sv
// Self-checking testbench for restricted_deque_core with directed and random deque commands.
`timescale 1ns / 1ps

module restricted_deque_core_test;
  import rdq_pkg::*;

  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 5;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int SETTLE_CYCLES  = DEPTH + 8;
  localparam int HOLD_CYCLES    = 300;

  localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] CMD_LAST_UNUSED  = 3'd7;

  localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_wdata = 1'b0;

  in_t  cmd_backlog[$];
  out_t owed_results[$];

  logic signed [DATA_W-1:0] model_words [DEPTH];
  int   model_head  = 0;
  int   model_count = 0;
  logic model_mode  = MODE_INPUT_RESTRICTED;

  int   in_gap      = 0;
  int   stall_left  = 0;
  logic no_idle     = 1'b0;
  logic hold_req    = 1'b0;
  logic hold_done   = 1'b0;
  int   fails       = 0;
  int   cycle_count = 0;
  out_t want;

  restricted_deque_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #HALF_PERIOD;
    clk = 1'b1;
    #HALF_PERIOD;
  end

  function automatic void owe(logic signed [DATA_W-1:0] v, logic [1:0] st, logic lst);
    out_t r;
    r.result_value = v;
    r.status       = st;
    r.last         = lst;
    owed_results.push_back(r);
  endfunction

  function automatic void deque_apply(in_t item);
    int i;
    case (item.command)
      CMD_PUSH_FRONT: begin
        if (model_count >= DEPTH) begin
          owe('0, ST_FULL, 1'b1);
        end else begin
          model_head = (model_head + DEPTH - 1) % DEPTH;
          model_words[model_head] = item.push_value;
          model_count++;
          owe('0, ST_OK, 1'b1);
        end
      end
      CMD_PUSH_BACK: begin
        if (model_mode == MODE_INPUT_RESTRICTED) begin
          owe('0, ST_REFUSED, 1'b1);
        end else if (model_count >= DEPTH) begin
          owe('0, ST_FULL, 1'b1);
        end else begin
          model_words[(model_head + model_count) % DEPTH] = item.push_value;
          model_count++;
          owe('0, ST_OK, 1'b1);
        end
      end
      CMD_POP_FRONT: begin
        if (model_count == 0) begin
          owe('0, ST_EMPTY, 1'b1);
        end else begin
          owe(model_words[model_head], ST_OK, 1'b1);
          model_head = (model_head + 1) % DEPTH;
          model_count--;
        end
      end
      CMD_POP_BACK: begin
        if (model_mode == MODE_OUTPUT_RESTRICTED) begin
          owe('0, ST_REFUSED, 1'b1);
        end else if (model_count == 0) begin
          owe('0, ST_EMPTY, 1'b1);
        end else begin
          owe(model_words[(model_head + model_count - 1) % DEPTH], ST_OK, 1'b1);
          model_count--;
        end
      end
      CMD_DUMP: begin
        if (model_count == 0) begin
          owe('0, ST_EMPTY, 1'b1);
        end else begin
          for (i = 0; i < model_count; i++)
            owe(model_words[(model_head + i) % DEPTH], ST_OK, i == model_count - 1);
        end
      end
      default: owe('0, ST_REFUSED, 1'b1);
    endcase
  endfunction

  function automatic void add_item(logic [2:0] c, logic signed [DATA_W-1:0] v);
    in_t it;
    it.command    = c;
    it.push_value = v;
    cmd_backlog.push_back(it);
  endfunction

  function automatic in_t make_item(int push_pct);
    in_t it;
    int  r;
    r = $urandom_range(0, 99);
    if (r < push_pct)
      it.command = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    else if (r < 90)
      it.command = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
    else if (r < 97)
      it.command = CMD_DUMP;
    else
      it.command = CMD_FIRST_UNUSED
                   + 3'($urandom_range(0, CMD_LAST_UNUSED - CMD_FIRST_UNUSED));
    case ($urandom_range(0, 7))
      0:       it.push_value = WORD_MAX;
      1:       it.push_value = WORD_MIN;
      default: it.push_value = $urandom;
    endcase
    return it;
  endfunction

  // wait for the backlog and every owed result to clear, then let the core go quiet
  task automatic settle();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || in_valid || owed_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_wdata <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    model_mode = m;
  endtask

  task automatic random_burst(input int n, input int push_pct);
    @(negedge clk);
    repeat (n) cmd_backlog.push_back(make_item(push_pct));
    settle();
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid)
        deque_apply(in_data);
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (cmd_backlog.size() == 0) begin
        in_valid <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        in_gap   <= $urandom_range(0, 4);
      end else begin
        in_data  <= cmd_backlog.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          $error("unexpected transaction: result_value %0d status %0d last %0d",
                 out_data.result_value, out_data.status, out_data.last);
          fails++;
        end else begin
          want = owed_results.pop_front();
          if (out_data.result_value !== want.result_value) begin
            $error("result_value: expected %0d, got %0d",
                   want.result_value, out_data.result_value);
            fails++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            fails++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_data.last);
            fails++;
          end
        end
      end
      if (hold_req && !hold_done) begin
        hold_done  <= 1'b1;
        stall_left <= HOLD_CYCLES;
        out_stall  <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        stall_left <= $urandom_range(0, 4);
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    while (cycle_count < TIMEOUT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("restricted_deque_core_test NOT OK");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // reset mode: input restricted
    @(negedge clk);
    add_item(CMD_POP_FRONT, '0);
    add_item(CMD_POP_BACK, '0);
    add_item(CMD_DUMP, '0);
    add_item(CMD_PUSH_BACK, WORD_MAX);
    add_item(CMD_FIRST_UNUSED, '0);
    add_item(CMD_LAST_UNUSED, WORD_MIN);
    add_item(CMD_PUSH_FRONT, WORD_MAX);
    add_item(CMD_PUSH_FRONT, WORD_MIN);
    add_item(CMD_PUSH_FRONT, -1);
    add_item(CMD_PUSH_FRONT, '0);
    add_item(CMD_DUMP, '0);
    add_item(CMD_POP_BACK, '0);
    add_item(CMD_POP_FRONT, '0);
    add_item(CMD_POP_FRONT, '0);
    add_item(CMD_POP_FRONT, '0);
    add_item(CMD_POP_FRONT, '0);
    settle();

    write_mode(MODE_OUTPUT_RESTRICTED);
    @(negedge clk);
    add_item(CMD_PUSH_BACK, 32'sh5555_5555);
    add_item(CMD_PUSH_BACK, 32'shAAAA_AAAA);
    add_item(CMD_POP_BACK, '0);
    add_item(CMD_PUSH_FRONT, 1);
    add_item(CMD_DUMP, '0);
    add_item(CMD_POP_FRONT, '0);
    add_item(CMD_POP_FRONT, '0);
    add_item(CMD_POP_FRONT, '0);
    add_item(CMD_FIRST_UNUSED + 3'd1, WORD_MAX);
    add_item(CMD_DUMP, '0);
    settle();

    // push-heavy with a long output hold-off so the core backs up
    hold_req <= 1'b1;
    random_burst(80, 70);

    write_mode(MODE_INPUT_RESTRICTED);
    random_burst(80, 25);

    write_mode(MODE_OUTPUT_RESTRICTED);
    random_burst(80, 50);

    write_mode(MODE_INPUT_RESTRICTED);
    random_burst(60, 60);

    write_mode(MODE_OUTPUT_RESTRICTED);
    no_idle <= 1'b1;
    random_burst(60, 50);

    if (fails == 0)
      $display("restricted_deque_core_test OK");
    else
      $display("restricted_deque_core_test NOT OK");
    $finish;
  end

endmodule
